/* rtl/assert_macros.svh */
// Assertion macros used by the verification checker of the list core.
// Depends on nothing; the including scope provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SAL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/sal_pkg.sv */
// Package for the shifting array list core: sizes, codes and payload types.
// Used by every module of the block; depends on nothing.
package sal_pkg;

  localparam int CAPACITY   = 256;
  localparam int ELEM_W     = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 8;
  localparam int DATA_W     = 32;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GROUP_SZ   = 16;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SZ - 1) / GROUP_SZ;

  typedef enum logic [2:0] {
    FN_INSERT   = 3'd0,
    FN_APPEND   = 3'd1,
    FN_REMOVE   = 3'd2,
    FN_SET      = 3'd3,
    FN_GET      = 3'd4,
    FN_CONTAINS = 3'd5
  } sal_func_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_BADPOS = 2'd2,
    STS_FULL   = 2'd3
  } sal_status_e;

  typedef enum logic [2:0] {
    CO_NONE,
    CO_INSERT,
    CO_REMOVE,
    CO_SET,
    CO_GET,
    CO_SCAN
  } sal_op_e;

  typedef enum logic [2:0] {
    SM_IDLE,
    SM_APPLY,
    SM_GROUP,
    SM_MERGE,
    SM_DONE
  } sal_state_e;

  typedef struct packed {
    logic [2:0]        func;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } sal_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              found;
    logic [1:0]        status;
    logic [8:0]        count;
  } sal_out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              go;
    sal_op_e           op;
    logic [IDX_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [ELEM_W-1:0] value;
  } sal_cmd_t;

endpackage

/* rtl/sal_cell.sv */
// One storage cell of the list chain: holds one entry, shifts with its
// neighbors and reports its own match and read data. Depends on sal_pkg.
module sal_cell (
  input  logic                      clk_i,
  input  logic [sal_pkg::IDX_W-1:0]  idx_i,
  input  sal_pkg::sal_cmd_t          cmd_i,
  input  logic [sal_pkg::ELEM_W-1:0] prev_i,
  input  logic [sal_pkg::ELEM_W-1:0] next_i,
  output logic [sal_pkg::ELEM_W-1:0] data_o,
  output logic                       hit_o,
  output logic [sal_pkg::ELEM_W-1:0] rd_o
);
  import sal_pkg::*;

  logic [ELEM_W-1:0] data_q, data_d;
  logic              hit_q, hit_d;
  logic [ELEM_W-1:0] rd_q, rd_d;
  logic              at_pos;

  assign at_pos = (idx_i == cmd_i.pos);

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CO_INSERT: begin
        if (idx_i > cmd_i.pos) begin
          data_d = prev_i;
        end else if (at_pos) begin
          data_d = cmd_i.value;
        end
      end
      CO_REMOVE: begin
        if (idx_i >= cmd_i.pos) begin
          data_d = next_i;
        end
      end
      CO_SET: begin
        if (at_pos) begin
          data_d = cmd_i.value;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  // Match and read use the contents from before this command.
  assign hit_d = (cmd_i.op == CO_SCAN) && ({1'b0, idx_i} < CNT_W'(cmd_i.count)) &&
                 (data_q == cmd_i.value);
  assign rd_d  = ((cmd_i.op == CO_GET) && at_pos) ? data_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.go) begin
      data_q <= data_d;
      hit_q  <= hit_d;
      rd_q   <= rd_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;
  assign rd_o   = rd_q;

endmodule

/* rtl/sal_reduce.sv */
// Two-level registered OR tree that gathers the match flags and read data
// of all cells into one flag and one word. Depends on sal_pkg.
module sal_reduce (
  input  logic                       clk_i,
  input  logic [sal_pkg::CAPACITY-1:0] hit_i,
  input  logic [sal_pkg::ELEM_W-1:0]   rd_i [sal_pkg::CAPACITY],
  output logic                         hit_o,
  output logic [sal_pkg::ELEM_W-1:0]   rd_o
);
  import sal_pkg::*;

  logic [NUM_GROUPS-1:0] grp_hit_q, grp_hit_d;
  logic [ELEM_W-1:0]     grp_rd_q [NUM_GROUPS];
  logic [ELEM_W-1:0]     grp_rd_d [NUM_GROUPS];
  logic                  hit_q, hit_d;
  logic [ELEM_W-1:0]     rd_q, rd_d;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_rd_d[g]  = '0;
      for (int k = 0; k < GROUP_SZ; k++) begin
        if (g * GROUP_SZ + k < CAPACITY) begin
          grp_hit_d[g] = grp_hit_d[g] | hit_i[g * GROUP_SZ + k];
          grp_rd_d[g]  = grp_rd_d[g] | rd_i[g * GROUP_SZ + k];
        end
      end
    end
  end

  always_comb begin
    hit_d = |grp_hit_q;
    rd_d  = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      rd_d = rd_d | grp_rd_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_hit_q <= grp_hit_d;
    grp_rd_q  <= grp_rd_d;
    hit_q     <= hit_d;
    rd_q      <= rd_d;
  end

  assign hit_o = hit_q;
  assign rd_o  = rd_q;

endmodule

/* rtl/shifting_array_list_core.sv */
// Top level of the shifting array list core: request decode, entry count,
// cell chain, reduction tree and output register. Depends on sal_pkg,
// sal_cell and sal_reduce.
//
// Usage: each input transaction carries one request (insert, append, remove,
// set, get or contains) with a position and a value. Every request produces
// exactly one output transaction with the read value, the found flag, a
// status code and the entry count after the request.
// The entries live in a chain of cells, one entry per cell. Insert and
// remove move every affected entry one cell along the chain all together;
// contains compares all cells at once.
// Sequence: a request passes through the accept step, the cell update, the
// two registered levels of the OR tree that collects match flags and read
// data, and the loading of the output register. A new request is accepted
// only after the previous result has been loaded into the output register.
// Reset: the list is empty after reset and no output is pending; cell
// contents are not cleared, positions at or above the count are never read.
// Stalls: a finished result waits in the output register while the next
// request is already accepted; the core holds a new result back only while
// the previous one is still waiting to be taken.
module shifting_array_list_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sal_pkg::sal_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sal_pkg::sal_out_t out_data_o
);
  import sal_pkg::*;

  sal_state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic             in_fire;

  // Decoded request, held for the duration of the transaction.
  sal_op_e           op_q, op_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  old_count_q;
  logic [ELEM_W-1:0] value_q;
  sal_status_e       status_q, status_d;

  sal_cmd_t          cell_cmd;
  logic [ELEM_W-1:0] cell_data [CAPACITY];
  logic [ELEM_W-1:0] cell_rd   [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;

  logic              tree_hit;
  logic [ELEM_W-1:0] tree_rd;

  logic     out_valid_q, out_valid_d;
  sal_out_t out_data_q;
  logic     out_load;

  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic             is_full, is_empty, pos_past, pos_beyond;

  assign in_ready_o = (state_q == SM_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Request decode against the count before the request.
  assign pos_ext    = CMP_W'(in_data_i.pos);
  assign cnt_ext    = CMP_W'(count_q);
  assign is_full    = (count_q == CNT_W'(CAPACITY));
  assign is_empty   = (count_q == '0);
  assign pos_past   = (pos_ext > cnt_ext);
  assign pos_beyond = (pos_ext >= cnt_ext);

  always_comb begin
    op_d     = CO_NONE;
    pos_d    = IDX_W'(in_data_i.pos);
    status_d = STS_OK;
    count_d  = count_q;
    case (in_data_i.func)
      FN_INSERT: begin
        if (is_full) begin
          status_d = STS_FULL;
        end else if (pos_past) begin
          status_d = STS_BADPOS;
        end else begin
          op_d    = CO_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      FN_APPEND: begin
        // An append is an insert at the current end of the list.
        if (is_full) begin
          status_d = STS_FULL;
        end else begin
          op_d    = CO_INSERT;
          pos_d   = count_q[IDX_W-1:0];
          count_d = count_q + 1'b1;
        end
      end
      FN_REMOVE, FN_SET, FN_GET: begin
        if (is_empty) begin
          status_d = STS_EMPTY;
        end else if (pos_beyond) begin
          status_d = STS_BADPOS;
        end else if (in_data_i.func == FN_REMOVE) begin
          op_d    = CO_REMOVE;
          count_d = count_q - 1'b1;
        end else if (in_data_i.func == FN_SET) begin
          op_d = CO_SET;
        end else begin
          op_d = CO_GET;
        end
      end
      FN_CONTAINS: begin
        op_d = CO_SCAN;
      end
      default: begin
        op_d = CO_NONE;
      end
    endcase
  end

  // Sequencer: apply in the cells, then two tree levels, then the output.
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      SM_IDLE: begin
        if (in_valid_i) begin
          state_d = SM_APPLY;
        end
      end
      SM_APPLY: state_d = SM_GROUP;
      SM_GROUP: state_d = SM_MERGE;
      SM_MERGE: state_d = SM_DONE;
      SM_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = SM_IDLE;
        end
      end
      default: state_d = SM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SM_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q        <= op_d;
      pos_q       <= pos_d;
      old_count_q <= count_q;
      value_q     <= in_data_i.value[ELEM_W-1:0];
      status_q    <= status_d;
    end
  end

  // The command reaches the cells for exactly one cycle.
  assign cell_cmd.go    = (state_q == SM_APPLY);
  assign cell_cmd.op    = op_q;
  assign cell_cmd.pos   = pos_q;
  assign cell_cmd.count = old_count_q;
  assign cell_cmd.value = value_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_W-1:0] prev_data, next_data;

    if (i == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_mid_prev
      assign prev_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid_next
      assign next_data = cell_data[i+1];
    end

    sal_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(i)),
      .cmd_i  (cell_cmd),
      .prev_i (prev_data),
      .next_i (next_data),
      .data_o (cell_data[i]),
      .hit_o  (cell_hit[i]),
      .rd_o   (cell_rd[i])
    );
  end

  sal_reduce u_reduce (
    .clk_i (clk_i),
    .hit_i (cell_hit),
    .rd_i  (cell_rd),
    .hit_o (tree_hit),
    .rd_o  (tree_rd)
  );

  // Output register: frees the request side while a result waits.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.read_value <= DATA_W'(tree_rd);
      out_data_q.found      <= tree_hit;
      out_data_q.status     <= status_q;
      out_data_q.count      <= 9'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/sal_checker.sv */
// Port-level checker for the shifting array list core and its bind.
// Depends on sal_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sal_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input sal_pkg::sal_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sal_pkg::sal_out_t out_data_o
);
  import sal_pkg::*;

  logic out_ok;
  logic rd_nonzero;

  assign out_ok     = (out_data_o.status == STS_OK);
  assign rd_nonzero = |out_data_o.read_value;

  // In the cycle after reset is seen low, no result is pending.
  `SAL_ASSERT_RST(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "output valid during reset")

  // The count never exceeds the list capacity.
  `SAL_ASSERT(a_count_cap, out_valid_o |-> (out_data_o.count <= 9'(CAPACITY)), "count too high")

  // A found flag only comes with a successful request.
  `SAL_ASSERT(a_found_ok, (out_valid_o && out_data_o.found) |-> out_ok, "found with error status")

  // Read data only comes from a successful get.
  `SAL_ASSERT(a_read_ok, (out_valid_o && rd_nonzero) |-> out_ok, "read data with error status")

  // One request is worked on at a time.
  `SAL_ASSERT(a_one_at_a_time, (in_valid_i && in_ready_o) |=> !in_ready_o, "taken while busy")

endmodule

bind shifting_array_list_core sal_checker u_sal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
